// ===== rtl/pfdm_pkg.sv =====
// Shared constants for the PWM frequency and duty meter.
`timescale 1ns / 1ps

package pfdm_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Register map: index of each configuration register.
  localparam logic REG_CLOCK_HZ = 1'b0;
  localparam logic [31:0] CLOCK_HZ_RESET = 32'd8000000;

  // Division schedule of the back end.
  localparam int FREQ_STEPS = 32;
  localparam int DUTY_STEPS = 7;
  localparam int STEP_CNT_WIDTH = 5;

endpackage

// ===== rtl/pwm_frequency_duty_meter.sv =====
// Top level of the PWM frequency and duty meter: register port, front end, queue and divider.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid / in_stall  signal_level
//   result    out        out_valid/out_stall  frequency_hz, duty_percent, high_ticks, low_ticks
//   config    in         APB write            clock_hz at byte address 0
//
// One sample is taken per cycle while the request queue has room. Each measurement request
// occupies the shared restoring divider through a load step, 32 frequency quotient bits, 7 duty
// bits and a hand-over step. Edges that come faster than the divider finishes requests fill the
// queue, and the input is then stalled. A held result keeps the divider from taking the next
// request. Reset is synchronous and clears all control state and clock_hz to 8 MHz.
`timescale 1ns / 1ps

module pwm_frequency_duty_meter #(
  parameter int COUNT_WIDTH = pfdm_pkg::COUNT_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH = pfdm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        signal_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] frequency_hz,
  output logic [6:0]  duty_percent,
  output logic [31:0] high_ticks,
  output logic [31:0] low_ticks
);

  logic [31:0]              clock_hz;
  logic                     queue_full;
  logic                     push;
  logic [2*COUNT_WIDTH-1:0] push_data;
  logic                     pop;
  logic                     req_ready;
  logic [2*COUNT_WIDTH-1:0] req_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == pfdm_pkg::REG_CLOCK_HZ) ? clock_hz : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= pfdm_pkg::CLOCK_HZ_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == pfdm_pkg::REG_CLOCK_HZ) begin
      clock_hz <= pwdata;
    end
  end

  pfdm_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .signal_level(signal_level),
    .queue_full  (queue_full),
    .push        (push),
    .push_data   (push_data)
  );

  pfdm_queue #(
    .WIDTH(2 * COUNT_WIDTH),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (queue_full),
    .pop      (pop),
    .not_empty(req_ready),
    .pop_data (req_data)
  );

  pfdm_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .clock_hz    (clock_hz),
    .req_ready   (req_ready),
    .req_data    (req_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frequency_hz(frequency_hz),
    .duty_percent(duty_percent),
    .high_ticks  (high_ticks),
    .low_ticks   (low_ticks)
  );

endmodule

// ===== rtl/pfdm_front.sv =====
// Edge detector and phase counter that turns input samples into measurement requests.
`timescale 1ns / 1ps

module pfdm_front #(
  parameter int COUNT_WIDTH = pfdm_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     signal_level,
  input  logic                     queue_full,
  output logic                     push,
  output logic [2*COUNT_WIDTH-1:0] push_data
);

  localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);

  logic                   previous_level;
  logic                   armed;
  logic [COUNT_WIDTH-1:0] phase_count;
  logic [COUNT_WIDTH-1:0] last_high;
  logic [COUNT_WIDTH-1:0] last_low;
  logic [1:0]             have_high_low;

  logic                   accept;
  logic                   rising;
  logic                   falling;
  logic [COUNT_WIDTH-1:0] last_high_next;
  logic [COUNT_WIDTH-1:0] last_low_next;
  logic [1:0]             have_high_low_next;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign rising   = signal_level && !previous_level;
  assign falling  = !signal_level && previous_level;

  always_comb begin
    last_high_next     = last_high;
    last_low_next      = last_low;
    have_high_low_next = have_high_low;
    if (falling) begin
      last_high_next        = phase_count;
      have_high_low_next[0] = 1'b1;
    end else if (rising) begin
      last_low_next         = phase_count;
      have_high_low_next[1] = 1'b1;
    end
  end

  // A request leaves only on an edge after arming, once both phases are known.
  assign push      = accept && armed && (rising || falling) && (have_high_low_next == 2'b11);
  assign push_data = {last_high_next, last_low_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b0;
      armed          <= 1'b0;
      phase_count    <= '0;
      last_high      <= '0;
      last_low       <= '0;
      have_high_low  <= 2'b00;
    end else if (accept) begin
      previous_level <= signal_level;
      if (!armed) begin
        if (rising) begin
          armed       <= 1'b1;
          phase_count <= CountOne;
        end
      end else if (rising || falling) begin
        last_high     <= last_high_next;
        last_low      <= last_low_next;
        have_high_low <= have_high_low_next;
        phase_count   <= CountOne;
      end else if (phase_count != '1) begin
        phase_count <= phase_count + CountOne;
      end
    end
  end

endmodule

// ===== rtl/pfdm_queue.sv =====
// Small first-in first-out queue between the front end and the divider.
`timescale 1ns / 1ps

module pfdm_queue #(
  parameter int WIDTH = 2 * pfdm_pkg::COUNT_WIDTH_DEFAULT,
  parameter int DEPTH = pfdm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntWidth = $clog2(DEPTH + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
  localparam logic [CntWidth-1:0] DepthCnt = CntWidth'(DEPTH);
  localparam logic [CntWidth-1:0] CntOne = CntWidth'(1);

  logic [WIDTH-1:0]    entries [DEPTH];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] fill;
  logic                do_push;
  logic                do_pop;

  assign full      = (fill == DepthCnt);
  assign not_empty = (fill != '0);
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrWidth'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CntOne;
      end else if (do_pop && !do_push) begin
        fill <= fill - CntOne;
      end
    end
  end

endmodule

// ===== rtl/pfdm_back.sv =====
// Shared restoring divider that works out frequency and duty, with the output register.
`timescale 1ns / 1ps

module pfdm_back #(
  parameter int COUNT_WIDTH = pfdm_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [31:0]              clock_hz,
  input  logic                     req_ready,
  input  logic [2*COUNT_WIDTH-1:0] req_data,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [31:0]              frequency_hz,
  output logic [6:0]               duty_percent,
  output logic [31:0]              high_ticks,
  output logic [31:0]              low_ticks
);

  localparam int PerWidth  = COUNT_WIDTH + 1;
  localparam int ProdWidth = COUNT_WIDTH + 7;
  localparam int CntW      = pfdm_pkg::STEP_CNT_WIDTH;
  localparam logic [CntW-1:0] FreqLast = CntW'(pfdm_pkg::FREQ_STEPS - 1);
  localparam logic [CntW-1:0] DutyLast = CntW'(pfdm_pkg::DUTY_STEPS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             state;
  logic                   duty_phase;
  logic [CntW-1:0]        step;
  logic [COUNT_WIDTH-1:0] high;
  logic [COUNT_WIDTH-1:0] low;
  logic [PerWidth-1:0]    period;
  logic [PerWidth-1:0]    rem;
  logic [31:0]            dvd;
  logic [31:0]            quo;
  logic [31:0]            freq_res;

  logic [PerWidth:0]      trial;
  logic                   qbit;
  logic [PerWidth-1:0]    rem_next;
  logic [ProdWidth-1:0]   high_ext;
  logic [ProdWidth-1:0]   high_x100;
  logic [COUNT_WIDTH+31:0] high_wide;
  logic [COUNT_WIDTH+31:0] low_wide;
  logic                   out_free;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == ST_IDLE) && req_ready;

  // One quotient bit per cycle: shift the next dividend bit into the remainder.
  always_comb begin
    trial    = {rem, dvd[31]};
    qbit     = (trial >= {1'b0, period});
    rem_next = qbit ? PerWidth'(trial - {1'b0, period}) : trial[PerWidth-1:0];
  end

  // 100 * high as shifts and adds; the quotient by period never exceeds 100,
  // so the top part of the product already sits below the divisor.
  always_comb begin
    high_ext  = {7'b0, high};
    high_x100 = (high_ext << 6) + (high_ext << 5) + (high_ext << 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      duty_phase <= 1'b0;
      step       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_ready) begin
            state      <= ST_RUN;
            duty_phase <= 1'b0;
            step       <= '0;
          end
        end
        ST_RUN: begin
          if (!duty_phase && step == FreqLast) begin
            duty_phase <= 1'b1;
            step       <= '0;
          end else if (duty_phase && step == DutyLast) begin
            state <= ST_DONE;
          end else begin
            step <= step + CntW'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      high   <= req_data[2*COUNT_WIDTH-1:COUNT_WIDTH];
      low    <= req_data[COUNT_WIDTH-1:0];
      period <= {1'b0, req_data[2*COUNT_WIDTH-1:COUNT_WIDTH]}
              + {1'b0, req_data[COUNT_WIDTH-1:0]};
      rem    <= '0;
      dvd    <= clock_hz;
      quo    <= '0;
    end else if (state == ST_RUN) begin
      if (!duty_phase && step == FreqLast) begin
        freq_res <= {quo[30:0], qbit};
        rem      <= {1'b0, high_x100[ProdWidth-1:7]};
        dvd      <= {high_x100[6:0], 25'b0};
        quo      <= '0;
      end else begin
        rem <= rem_next;
        dvd <= {dvd[30:0], 1'b0};
        quo <= {quo[30:0], qbit};
      end
    end
  end

  always_comb begin
    high_wide = {32'b0, high};
    low_wide  = {32'b0, low};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      if (period == '0) begin
        frequency_hz <= '0;
        duty_percent <= '0;
      end else begin
        frequency_hz <= freq_res;
        duty_percent <= quo[6:0];
      end
      // Tick counts wider than the output port saturate.
      high_ticks <= (high_wide[COUNT_WIDTH+31:32] != '0) ? '1 : high_wide[31:0];
      low_ticks  <= (low_wide[COUNT_WIDTH+31:32] != '0) ? '1 : low_wide[31:0];
    end
  end

endmodule

// ===== bench/pwm_frequency_duty_meter_tb.sv =====
// Self-checking testbench for the PWM frequency and duty meter.
`timescale 1ns / 1ps

module pwm_frequency_duty_meter_tb;

  localparam int          COUNT_WIDTH   = pfdm_pkg::COUNT_WIDTH_DEFAULT;
  localparam bit [63:0]   COUNT_MAX     = (64'd1 << COUNT_WIDTH) - 64'd1;
  localparam bit [63:0]   TICKS_MAX     = 64'hFFFF_FFFF;
  localparam bit [63:0]   PERCENT       = 64'd100;
  localparam logic [2:0]  ADDR_CLOCK_HZ = {pfdm_pkg::REG_CLOCK_HZ, 2'b00};
  localparam logic [2:0]  ADDR_UNMAPPED = 3'd4;
  localparam int          RESET_CYCLES  = 10;
  localparam int          SETTLE_CYCLES = 200;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          CYCLE_LIMIT   = 500000;
  localparam int          CHUNK_ITEMS   = 100;

  typedef struct packed {
    logic [31:0] frequency_hz;
    logic [6:0]  duty_percent;
    logic [31:0] high_ticks;
    logic [31:0] low_ticks;
  } measurement_t;

  class meter_scoreboard;
    bit [31:0]    clock_hz;
    bit           prev_level;
    bit           armed;
    bit [63:0]    phase_count;
    bit [63:0]    last_high;
    bit [63:0]    last_low;
    bit           high_known;
    bit           low_known;
    measurement_t expected_measurements[$];
    int           mismatches;

    function new();
      clock_hz    = pfdm_pkg::CLOCK_HZ_RESET;
      prev_level  = 1'b0;
      armed       = 1'b0;
      phase_count = '0;
      last_high   = '0;
      last_low    = '0;
      high_known  = 1'b0;
      low_known   = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_clock(bit [31:0] value);
      clock_hz = value;
    endfunction

    // Advances the meter by one accepted sample and queues a measurement at each edge that
    // closes a full period.
    function void note_level(bit lvl);
      bit           rising;
      bit           falling;
      bit [63:0]    period;
      bit [63:0]    freq;
      bit [63:0]    duty;
      measurement_t m;
      rising     = lvl && !prev_level;
      falling    = !lvl && prev_level;
      prev_level = lvl;
      if (!armed) begin
        if (rising) begin
          armed       = 1'b1;
          phase_count = 64'd1;
        end
        return;
      end
      if (rising || falling) begin
        if (falling) begin
          last_high  = phase_count;
          high_known = 1'b1;
        end else begin
          last_low  = phase_count;
          low_known = 1'b1;
        end
        phase_count = 64'd1;
        if (high_known && low_known) begin
          period = last_high + last_low;
          freq   = '0;
          duty   = '0;
          if (period != 0) begin
            freq = {32'd0, clock_hz} / period;
            duty = (last_high * PERCENT) / period;
          end
          m.frequency_hz = freq[31:0];
          m.duty_percent = duty[6:0];
          m.high_ticks   = (last_high > TICKS_MAX) ? '1 : last_high[31:0];
          m.low_ticks    = (last_low > TICKS_MAX) ? '1 : last_low[31:0];
          expected_measurements.push_back(m);
        end
      end else if (phase_count < COUNT_MAX) begin
        phase_count++;
      end
    endfunction

    function void check_result(measurement_t got);
      measurement_t want;
      if (expected_measurements.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected measurement: freq %0d duty %0d high %0d low %0d",
                   got.frequency_hz, got.duty_percent, got.high_ticks, got.low_ticks);
        return;
      end
      want = expected_measurements.pop_front();
      if (got.frequency_hz !== want.frequency_hz || got.duty_percent !== want.duty_percent ||
          got.high_ticks !== want.high_ticks || got.low_ticks !== want.low_ticks) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want f %0d d %0d h %0d l %0d, got f %0d d %0d h %0d l %0d",
                   want.frequency_hz, want.duty_percent, want.high_ticks, want.low_ticks,
                   got.frequency_hz, got.duty_percent, got.high_ticks, got.low_ticks);
      end
    endfunction

    function void check_clock_readback(logic [31:0] got);
      if (got !== clock_hz) begin
        mismatches++;
        if (mismatches <= 10)
          $display("clock_hz readback mismatch: expected %0d, got %0d", clock_hz, got);
      end
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic        signal_level = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [31:0] frequency_hz;
  logic [6:0]  duty_percent;
  logic [31:0] high_ticks;
  logic [31:0] low_ticks;

  logic        no_idle      = 1'b0;
  logic        hold_request = 1'b0;
  logic        hold_active  = 1'b0;
  int          stall_left   = 0;
  int          cycle_count  = 0;

  meter_scoreboard sb;

  pwm_frequency_duty_meter dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .signal_level (signal_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frequency_hz (frequency_hz),
    .duty_percent (duty_percent),
    .high_ticks   (high_ticks),
    .low_ticks    (low_ticks)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pwm_frequency_duty_meter test failed");
      $finish;
    end
  end

  // Result side: takes a measurement whenever one is offered and not stalled, then stalls for a
  // random number of cycles, or for the whole long hold-off.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid === 1'b1 && !out_stall) begin
        sb.check_result({frequency_hz, duty_percent, high_ticks, low_ticks});
        stall_left = no_idle ? 0 : $urandom_range(0, 6);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= hold_active || (stall_left > 0);
    end
  end

  // Long hold-off on the result side, so that the request queue fills and the input stalls.
  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_CLOCK_HZ)
      sb.set_clock(data);
    @(posedge clk);
  endtask

  task automatic apb_read_clock();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_CLOCK_HZ;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_clock_readback(prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_clock_hz(logic [31:0] value);
    apb_write(ADDR_CLOCK_HZ, value);
    apb_read_clock();
  endtask

  task automatic send_level(bit lvl);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    signal_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_level(lvl);
  endtask

  task automatic send_run(bit lvl, int len);
    repeat (len) send_level(lvl);
  endtask

  // Mostly short phases so that edges pile up behind the divider; now and then a long one.
  function automatic int pulse_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 98) return $urandom_range(9, 40);
    return $urandom_range(41, 300);
  endfunction

  task automatic random_chunk(int n);
    int sent;
    int len;
    sent = 0;
    no_idle <= ($urandom_range(0, 3) == 0);
    while (sent < n) begin
      if ($urandom_range(0, 99) < 85) begin
        len = pulse_len();
        send_run(1'b1, len);
        sent += len;
        len = pulse_len();
        send_run(1'b0, len);
        sent += len;
      end else begin
        len = $urandom_range(1, 10);
        repeat (len) send_level(1'($urandom_range(0, 1)));
        sent += len;
      end
    end
  endtask

  // Lowers the input request, waits for every pending measurement and lets the divider go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_measurements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_read_clock();

    // High on the very first sample arms the meter, then single-tick and lopsided periods.
    send_run(1'b1, 3);
    send_run(1'b0, 2);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 8);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 8);
    send_run(1'b1, 1);
    drain();

    hold_request <= 1'b1;
    random_chunk(CHUNK_ITEMS);
    drain();

    set_clock_hz(32'hFFFF_FFFF);
    random_chunk(CHUNK_ITEMS);
    drain();

    set_clock_hz(32'd1);
    random_chunk(CHUNK_ITEMS);
    drain();

    // A zero tick rate gives a zero frequency; a write to an unmapped address changes nothing.
    set_clock_hz(32'd0);
    apb_write(ADDR_UNMAPPED, 32'h00F4_2400);
    apb_read_clock();
    random_chunk(CHUNK_ITEMS);
    drain();

    set_clock_hz($urandom);
    random_chunk(CHUNK_ITEMS);
    drain();

    set_clock_hz($urandom_range(1, 1000));
    random_chunk(CHUNK_ITEMS);
    drain();

    if (sb.mismatches == 0 && sb.expected_measurements.size() == 0) begin
      $display("pwm_frequency_duty_meter test passed");
    end else begin
      $display("pwm_frequency_duty_meter test failed");
    end
    $finish;
  end

endmodule
